@@ rtl/core/smcp_pkg.sv @@
// ----------------------------------------------------------------------------
// smcp_pkg
// Types and constants of the serial motion command parser.
// ----------------------------------------------------------------------------
package smcp_pkg;

  typedef enum logic [2:0] {
    KIND_VEL    = 3'd0,
    KIND_MANUAL = 3'd1,
    KIND_AI     = 3'd2,
    KIND_PONG   = 3'd3,
    KIND_STOP   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_RD,
    ST_P1_EX,
    ST_DECIDE,
    ST_P2_RD,
    ST_P2_EX,
    ST_FR_RD,
    ST_FR_MUL,
    ST_FR_ACC,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    FP_START,
    FP_INT,
    FP_FRAC,
    FP_DONE
  } fpst_e;

  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [7:0]  CH_TILDE   = 8'd126;
  localparam logic [7:0]  CH_MINUS   = "-";
  localparam logic [7:0]  CH_DOT     = ".";
  localparam logic [7:0]  CH_COMMA   = ",";
  localparam logic [7:0]  CH_ZERO    = "0";
  localparam logic [7:0]  CH_NINE    = "9";
  localparam logic [16:0] IDLE_CAP   = 17'h1FFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd500;
  localparam logic [31:0] RECIP_TEN  = 32'hCCCCCCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam logic [32:0] IP_CAP     = 33'h1_0000_0000;

endpackage

@@ rtl/core/serial_motion_command_parser_unit.sv @@
// ----------------------------------------------------------------------------
// serial_motion_command_parser_unit
// Line parser for VEL, MODE and PING commands with a millisecond watchdog.
// ----------------------------------------------------------------------------
// A request is a received byte (cmd_i = 0) or a millisecond tick (cmd_i = 1).
// A byte, a tick without a stop or an empty line end leaves the block idle.
// A line end walks the stored line once through the single line store read
// port, read and execute states a character, then decides. A VEL line walks
// the line a second time the same way and converts the fraction digits of
// each field through one shared multiply-by-reciprocal unit, with read,
// multiply and accumulate states a digit and read and finish states a
// field. Every result, a stop included, then passes the emit state, held
// while the output register still carries an unaccepted result. The block
// holds in_ready_o low while it works and while it waits to emit.
module serial_motion_command_parser_unit #(
  parameter int LINE_MAX  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] vel_turn_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = $clog2(LINE_MAX);
  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int XW = FRAC_BITS + 4;
  localparam int PW = XW + 32;
  localparam logic [32:0] IpLim = 33'd1 << (31 - FRAC_BITS);

  smcp_pkg::state_e state_q, state_d;

  logic [7:0]  store_mem [LINE_MAX];
  logic [3:0]  dig_mem   [LINE_MAX];
  logic [7:0]  st_rd_q;
  logic [3:0]  dig_rd_q;

  logic [LW-1:0] line_len_q, wlen_q, idx_q, dn_q;
  logic [16:0]   idle_q;
  logic [15:0]   timeout_q;

  logic          seen_q;
  logic [2:0]    pre_q;
  logic [3:0][7:0] pfx_q;
  logic [1:0]    spc_cnt_q, spc_pend_q;
  logic [47:0]   win_q;
  logic          man_q, ai_q;

  logic [1:0]    fld_q;
  logic          end_q;
  smcp_pkg::fpst_e fp_q;
  logic          neg_q;
  logic [32:0]   ip_q;
  logic [FRAC_BITS-1:0] y_q;
  logic [PW-1:0] prod_q;
  logic [31:0]   vx_q, vy_q, vt_q;
  logic [2:0]    res_kind_q;

  logic          out_valid_q;
  logic [2:0]    out_kind_q;
  logic [31:0]   out_x_q, out_y_q, out_t_q;

  logic          in_acc, eol, store_we, stop, last, prn, issp, isdig, isdot;
  logic          is_vel, is_mode, is_ping, space_fin, out_free;
  logic [16:0]   idle_inc;
  logic [7:0]    c;
  logic [47:0]   win_n;
  logic [2:0]    spc_sum;
  logic [36:0]   ip_ext, ip_acc;
  logic [XW-1:0] fr_x;
  logic [31:0]   mag32, fval;
  logic [AW-1:0] dig_ra;

  assign in_acc   = in_valid_i && in_ready_o;
  assign eol      = (rx_byte_i == smcp_pkg::CH_LF) || (rx_byte_i == smcp_pkg::CH_CR);
  assign store_we = in_acc && !cmd_i && !eol && (line_len_q < LW'(LINE_MAX));
  assign idle_inc = (idle_q == smcp_pkg::IDLE_CAP) ? idle_q : idle_q + 17'd1;
  assign stop     = idle_inc > {1'b0, timeout_q};
  assign c        = st_rd_q;
  assign prn      = (c >= smcp_pkg::CH_SPACE) && (c <= smcp_pkg::CH_TILDE);
  assign issp     = c == smcp_pkg::CH_SPACE;
  assign isdig    = (c >= smcp_pkg::CH_ZERO) && (c <= smcp_pkg::CH_NINE);
  assign isdot    = (c == smcp_pkg::CH_DOT) || (c == smcp_pkg::CH_COMMA);
  assign last     = (idx_q + LW'(1)) == wlen_q;
  assign win_n    = {win_q[39:0], c};
  assign spc_sum  = {1'b0, spc_cnt_q} + {1'b0, spc_pend_q};
  assign space_fin = prn && issp && seen_q && (fld_q != 2'd0) && (fld_q != 2'd3);
  assign out_free = !out_valid_q || out_ready_i;
  assign dig_ra   = AW'(dn_q - LW'(1));

  assign is_vel  = (pre_q >= 3'd3) && (pfx_q[0] == "V") && (pfx_q[1] == "E")
                   && (pfx_q[2] == "L");
  assign is_mode = (pre_q == 3'd4) && (pfx_q[0] == "M") && (pfx_q[1] == "O")
                   && (pfx_q[2] == "D") && (pfx_q[3] == "E");
  assign is_ping = (pre_q == 3'd4) && (pfx_q[0] == "P") && (pfx_q[1] == "I")
                   && (pfx_q[2] == "N") && (pfx_q[3] == "G");

  assign ip_ext = {4'b0, ip_q};
  assign ip_acc = (ip_ext << 3) + (ip_ext << 1) + {33'b0, c[3:0]};
  assign fr_x   = {dig_rd_q, {FRAC_BITS{1'b0}}} + {4'b0, y_q};
  assign mag32  = {ip_q[31-FRAC_BITS:0], y_q};

  always_comb begin
    if (neg_q) begin
      if ((ip_q > IpLim) || ((ip_q == IpLim) && (y_q != '0))) fval = 32'h8000_0000;
      else fval = 32'd0 - mag32;
    end else begin
      if (ip_q >= IpLim) fval = 32'h7FFF_FFFF;
      else fval = mag32;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_mem[line_len_q[AW-1:0]] <= rx_byte_i;
    st_rd_q <= store_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == smcp_pkg::ST_P2_EX && prn && !issp && seen_q && fld_q != 2'd0 &&
        fp_q == smcp_pkg::FP_FRAC && isdig) begin
      dig_mem[dn_q[AW-1:0]] <= c[3:0];
    end
    dig_rd_q <= dig_mem[dig_ra];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      smcp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i) begin
            if (stop) state_d = smcp_pkg::ST_EMIT;
          end else if (eol && line_len_q != '0) begin
            state_d = smcp_pkg::ST_P1_RD;
          end
        end
      end
      smcp_pkg::ST_P1_RD: state_d = smcp_pkg::ST_P1_EX;
      smcp_pkg::ST_P1_EX: state_d = last ? smcp_pkg::ST_DECIDE : smcp_pkg::ST_P1_RD;
      smcp_pkg::ST_DECIDE: begin
        if (is_vel) state_d = (spc_cnt_q == 2'd3) ? smcp_pkg::ST_P2_RD : smcp_pkg::ST_IDLE;
        else if (is_mode) state_d = (man_q || ai_q) ? smcp_pkg::ST_EMIT : smcp_pkg::ST_IDLE;
        else if (is_ping) state_d = smcp_pkg::ST_EMIT;
        else state_d = smcp_pkg::ST_IDLE;
      end
      smcp_pkg::ST_P2_RD: state_d = smcp_pkg::ST_P2_EX;
      smcp_pkg::ST_P2_EX: state_d = (last || space_fin) ? smcp_pkg::ST_FR_RD
                                                        : smcp_pkg::ST_P2_RD;
      smcp_pkg::ST_FR_RD: state_d = (dn_q == '0) ? smcp_pkg::ST_FIN : smcp_pkg::ST_FR_MUL;
      smcp_pkg::ST_FR_MUL: state_d = smcp_pkg::ST_FR_ACC;
      smcp_pkg::ST_FR_ACC: state_d = smcp_pkg::ST_FR_RD;
      smcp_pkg::ST_FIN: state_d = end_q ? smcp_pkg::ST_EMIT : smcp_pkg::ST_P2_RD;
      smcp_pkg::ST_EMIT: state_d = out_free ? smcp_pkg::ST_IDLE : smcp_pkg::ST_EMIT;
      default: state_d = smcp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = state_q == smcp_pkg::ST_IDLE;
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
    kind_o      = out_kind_q;
    vel_x_o     = out_x_q;
    vel_y_o     = out_y_q;
    vel_turn_o  = out_t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smcp_pkg::ST_IDLE;
      line_len_q  <= '0;
      idle_q      <= '0;
      timeout_q   <= smcp_pkg::TIMEOUT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) timeout_q <= cfg_data_i;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (store_we) line_len_q <= line_len_q + LW'(1);
      case (state_q)
        smcp_pkg::ST_IDLE: begin
          if (in_acc && cmd_i) begin
            idle_q     <= idle_inc;
            res_kind_q <= smcp_pkg::KIND_STOP;
          end
          if (in_acc && !cmd_i && eol && line_len_q != '0) begin
            wlen_q     <= line_len_q;
            line_len_q <= '0;
            idx_q      <= '0;
            seen_q     <= 1'b0;
            pre_q      <= '0;
            spc_cnt_q  <= '0;
            spc_pend_q <= '0;
            win_q      <= '0;
            man_q      <= 1'b0;
            ai_q       <= 1'b0;
          end
        end
        smcp_pkg::ST_P1_EX: begin
          idx_q <= idx_q + LW'(1);
          if (prn) begin
            win_q <= win_n;
            if (win_n == "MANUAL") man_q <= 1'b1;
            if (win_n[15:0] == "AI") ai_q <= 1'b1;
            if ((seen_q || !issp) && pre_q < 3'd4) begin
              pfx_q[pre_q[1:0]] <= c;
              pre_q <= pre_q + 3'd1;
            end
            if (!issp) begin
              seen_q <= 1'b1;
              if (seen_q) begin
                spc_cnt_q  <= (spc_sum > 3'd3) ? 2'd3 : spc_sum[1:0];
                spc_pend_q <= '0;
              end
            end else if (seen_q && spc_pend_q != 2'd3) begin
              spc_pend_q <= spc_pend_q + 2'd1;
            end
          end
        end
        smcp_pkg::ST_DECIDE: begin
          res_kind_q <= smcp_pkg::KIND_VEL;
          if (is_vel) begin
            idx_q  <= '0;
            seen_q <= 1'b0;
            fld_q  <= '0;
            end_q  <= 1'b0;
            fp_q   <= smcp_pkg::FP_START;
            neg_q  <= 1'b0;
            ip_q   <= '0;
            dn_q   <= '0;
            y_q    <= '0;
          end else if (is_mode) begin
            idle_q     <= '0;
            res_kind_q <= man_q ? smcp_pkg::KIND_MANUAL : smcp_pkg::KIND_AI;
          end else if (is_ping) begin
            idle_q     <= '0;
            res_kind_q <= smcp_pkg::KIND_PONG;
          end
        end
        smcp_pkg::ST_P2_EX: begin
          idx_q <= idx_q + LW'(1);
          if (last) end_q <= 1'b1;
          if (prn && issp && seen_q && fld_q == 2'd0) fld_q <= 2'd1;
          if (prn && !issp) begin
            seen_q <= 1'b1;
            if (seen_q && fld_q != 2'd0) begin
              case (fp_q)
                smcp_pkg::FP_START: begin
                  if (c == smcp_pkg::CH_MINUS) begin
                    neg_q <= 1'b1;
                    fp_q  <= smcp_pkg::FP_INT;
                  end else if (isdig) begin
                    ip_q <= ip_acc[32:0];
                    fp_q <= smcp_pkg::FP_INT;
                  end else if (isdot) begin
                    fp_q <= smcp_pkg::FP_FRAC;
                  end
                end
                smcp_pkg::FP_INT: begin
                  if (isdig) begin
                    ip_q <= (ip_acc > {4'b0, smcp_pkg::IP_CAP}) ? smcp_pkg::IP_CAP
                                                                : ip_acc[32:0];
                  end else if (isdot) begin
                    fp_q <= smcp_pkg::FP_FRAC;
                  end else if (c == smcp_pkg::CH_MINUS) begin
                    fp_q <= smcp_pkg::FP_DONE;
                  end
                end
                smcp_pkg::FP_FRAC: begin
                  if (isdig) dn_q <= dn_q + LW'(1);
                  else if (c == smcp_pkg::CH_MINUS || isdot) fp_q <= smcp_pkg::FP_DONE;
                end
                default: fp_q <= smcp_pkg::FP_DONE;
              endcase
            end
          end
        end
        smcp_pkg::ST_FR_RD: begin
          if (dn_q != '0) dn_q <= dn_q - LW'(1);
        end
        smcp_pkg::ST_FR_MUL: prod_q <= {32'b0, fr_x} * {{XW{1'b0}}, smcp_pkg::RECIP_TEN};
        smcp_pkg::ST_FR_ACC: y_q <= prod_q[smcp_pkg::RECIP_SHIFT +: FRAC_BITS];
        smcp_pkg::ST_FIN: begin
          case (fld_q)
            2'd1:    vx_q <= fval;
            2'd2:    vy_q <= fval;
            default: vt_q <= fval;
          endcase
          if (end_q) idle_q <= '0;
          else fld_q <= fld_q + 2'd1;
          fp_q  <= smcp_pkg::FP_START;
          neg_q <= 1'b0;
          ip_q  <= '0;
          dn_q  <= '0;
          y_q   <= '0;
        end
        smcp_pkg::ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= res_kind_q;
            if (res_kind_q == smcp_pkg::KIND_VEL) begin
              out_x_q <= vx_q;
              out_y_q <= vy_q;
              out_t_q <= vt_q;
            end else begin
              out_x_q <= '0;
              out_y_q <= '0;
              out_t_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_byte_stays_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cmd_i && rx_byte_i != smcp_pkg::CH_LF &&
    rx_byte_i != smcp_pkg::CH_CR |=> in_ready_o)
    else $error("byte request left the block busy");
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_len_q <= LW'(LINE_MAX))
    else $error("line length beyond store depth");
  a_vel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != smcp_pkg::KIND_VEL |->
    vel_x_o == '0 && vel_y_o == '0 && vel_turn_o == '0)
    else $error("non-velocity result carries velocity");
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == smcp_pkg::ST_EMIT && out_free |=> out_valid_o)
    else $error("result not loaded");
`endif

endmodule
